>>> rtl/jsesc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsesc_pkg
// Shared types, constants and helpers of the JSON string escaper.
// ----------------------------------------------------------------------------
package jsesc_pkg;

  localparam int unsigned LENGTH_BITS = 16;
  localparam int unsigned SUM_W       = (LENGTH_BITS > 16 ? LENGTH_BITS : 16) + 1;
  localparam int unsigned CAP_W       = 16;
  localparam int unsigned TOTAL_W     = 16;
  localparam int unsigned MAX_BYTES   = 6;
  localparam int unsigned CNT_W       = $clog2(MAX_BYTES + 1);
  localparam int unsigned IDX_W       = $clog2(MAX_BYTES);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CAP_W-1:0] CAP_RESET = 16'd1024;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [7:0] LEAD2_LO  = 8'hC2;
  localparam logic [7:0] LEAD2_HI  = 8'hDF;
  localparam logic [7:0] LEAD3_LO  = 8'hE0;
  localparam logic [7:0] LEAD3_HI  = 8'hEF;
  localparam logic [7:0] LEAD4_LO  = 8'hF0;
  localparam logic [7:0] LEAD4_HI  = 8'hF4;
  localparam logic [7:0] LEAD_ED   = 8'hED;
  localparam logic [7:0] CONT_A0   = 8'hA0;
  localparam logic [7:0] CONT_90   = 8'h90;
  localparam logic [7:0] ASCII_TOP = 8'h80;
  localparam logic [7:0] CTRL_TOP  = 8'h20;

  typedef enum logic [2:0] {
    CMD_RESET  = 3'd0,
    CMD_OPEN   = 3'd1,
    CMD_STRING = 3'd2,
    CMD_CLOSE  = 3'd3,
    CMD_RAW    = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          count;
    logic                      fail;
    logic [TOTAL_W-1:0]        length;
  } burst_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h57 + {4'd0, nib};
    end
    return r;
  endfunction

endpackage

>>> rtl/jsesc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsesc_front
// Command decode, escaping, UTF-8 checking and length accounting.
// ----------------------------------------------------------------------------
module jsesc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [jsesc_pkg::CAP_W-1:0]   cfg_wdata_i,
  input  logic                          push_i,
  input  logic [2:0]                    command_i,
  input  logic [7:0]                    data_byte_i,
  output jsesc_pkg::burst_t             burst_o
);

  logic [jsesc_pkg::CAP_W-1:0]       cap_q;
  logic [jsesc_pkg::LENGTH_BITS-1:0] len_q, len_d;
  logic                              fail_q, fail_d;
  logic [1:0]                        pcnt_q, pcnt_d;
  logic [1:0]                        need_q, need_d;
  logic [2:0][7:0]                   pend_q;
  logic                              pend_we;
  logic [1:0]                        pend_wa;

  jsesc_pkg::cmd_e                          cmd;
  logic [jsesc_pkg::MAX_BYTES-1:0][7:0]     req_b;
  logic [jsesc_pkg::CNT_W-1:0]              req_n, emit_n;
  logic                                     force_fail, bad;
  logic [jsesc_pkg::SUM_W-1:0]              sum;
  logic [7:0]                               c;

  assign cmd = jsesc_pkg::cmd_e'(command_i);
  assign c   = data_byte_i;
  assign sum = jsesc_pkg::SUM_W'(len_q) + jsesc_pkg::SUM_W'(req_n);

  always_comb begin
    len_d      = len_q;
    fail_d     = fail_q;
    pcnt_d     = pcnt_q;
    need_d     = need_q;
    pend_we    = 1'b0;
    pend_wa    = pcnt_q;
    req_b      = '0;
    req_n      = '0;
    emit_n     = '0;
    force_fail = 1'b0;
    bad        = 1'b0;
    if (cmd == jsesc_pkg::CMD_RESET) begin
      len_d  = '0;
      pcnt_d = '0;
      need_d = '0;
      fail_d = (cap_q == '0);
    end else if ((cmd == jsesc_pkg::CMD_OPEN || cmd == jsesc_pkg::CMD_CLOSE ||
                  cmd == jsesc_pkg::CMD_RAW) && pcnt_q != 2'd0) begin
      pcnt_d     = '0;
      need_d     = '0;
      force_fail = 1'b1;
    end else begin
      unique case (cmd) inside
        jsesc_pkg::CMD_OPEN, jsesc_pkg::CMD_CLOSE: begin
          req_b[0] = jsesc_pkg::CH_QUOTE;
          req_n    = jsesc_pkg::CNT_W'(1);
        end
        jsesc_pkg::CMD_RAW: begin
          req_b[0] = c;
          req_n    = jsesc_pkg::CNT_W'(1);
        end
        jsesc_pkg::CMD_STRING: begin
          if (pcnt_q == 2'd0) begin
            if (c < jsesc_pkg::ASCII_TOP) begin
              req_b[0] = jsesc_pkg::CH_BSL;
              req_n    = jsesc_pkg::CNT_W'(2);
              unique case (c)
                jsesc_pkg::CH_QUOTE: req_b[1] = jsesc_pkg::CH_QUOTE;
                jsesc_pkg::CH_BSL:   req_b[1] = jsesc_pkg::CH_BSL;
                jsesc_pkg::CH_BS:    req_b[1] = jsesc_pkg::CH_B;
                jsesc_pkg::CH_FF:    req_b[1] = jsesc_pkg::CH_F;
                jsesc_pkg::CH_LF:    req_b[1] = jsesc_pkg::CH_N;
                jsesc_pkg::CH_CR:    req_b[1] = jsesc_pkg::CH_R;
                jsesc_pkg::CH_TAB:   req_b[1] = jsesc_pkg::CH_T;
                default: begin
                  if (c < jsesc_pkg::CTRL_TOP) begin
                    req_b[1] = jsesc_pkg::CH_U;
                    req_b[2] = jsesc_pkg::CH_ZERO;
                    req_b[3] = jsesc_pkg::CH_ZERO;
                    req_b[4] = jsesc_pkg::hex_char(c[7:4]);
                    req_b[5] = jsesc_pkg::hex_char(c[3:0]);
                    req_n    = jsesc_pkg::CNT_W'(6);
                  end else begin
                    req_b[0] = c;
                    req_n    = jsesc_pkg::CNT_W'(1);
                  end
                end
              endcase
            end else if (c >= jsesc_pkg::LEAD2_LO && c <= jsesc_pkg::LEAD2_HI) begin
              need_d  = 2'd1;
              pend_we = 1'b1;
              pcnt_d  = 2'd1;
            end else if (c >= jsesc_pkg::LEAD3_LO && c <= jsesc_pkg::LEAD3_HI) begin
              need_d  = 2'd2;
              pend_we = 1'b1;
              pcnt_d  = 2'd1;
            end else if (c >= jsesc_pkg::LEAD4_LO && c <= jsesc_pkg::LEAD4_HI) begin
              need_d  = 2'd3;
              pend_we = 1'b1;
              pcnt_d  = 2'd1;
            end else begin
              force_fail = 1'b1;
            end
          end else begin
            bad = (c[7:6] != 2'b10);
            if (pcnt_q == 2'd1) begin
              if ((pend_q[0] == jsesc_pkg::LEAD3_LO && c <  jsesc_pkg::CONT_A0) ||
                  (pend_q[0] == jsesc_pkg::LEAD_ED  && c >= jsesc_pkg::CONT_A0) ||
                  (pend_q[0] == jsesc_pkg::LEAD4_LO && c <  jsesc_pkg::CONT_90) ||
                  (pend_q[0] == jsesc_pkg::LEAD4_HI && c >= jsesc_pkg::CONT_90)) begin
                bad = 1'b1;
              end
            end
            if (bad) begin
              pcnt_d     = '0;
              need_d     = '0;
              force_fail = 1'b1;
            end else if (pcnt_q < need_q) begin
              pend_we = 1'b1;
              pcnt_d  = pcnt_q + 2'd1;
            end else begin
              for (int i = 0; i < 3; i++) begin
                req_b[i] = (2'(i) < pcnt_q) ? pend_q[i] : c;
              end
              req_b[3] = c;
              req_n    = jsesc_pkg::CNT_W'(pcnt_q) + jsesc_pkg::CNT_W'(1);
              pcnt_d   = '0;
              need_d   = '0;
            end
          end
        end
        default: begin
        end
      endcase
      if (req_n != '0) begin
        if (fail_q || sum >= jsesc_pkg::SUM_W'(cap_q) ||
            (|(sum >> jsesc_pkg::LENGTH_BITS))) begin
          force_fail = 1'b1;
        end else begin
          emit_n = req_n;
          len_d  = sum[jsesc_pkg::LENGTH_BITS-1:0];
        end
      end
    end
    if (force_fail) begin
      fail_d = 1'b1;
      len_d  = '0;
    end
  end

  assign burst_o.bytes  = req_b;
  assign burst_o.count  = emit_n;
  assign burst_o.fail   = fail_d;
  assign burst_o.length = jsesc_pkg::TOTAL_W'(len_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= jsesc_pkg::CAP_RESET;
      len_q  <= '0;
      fail_q <= 1'b0;
      pcnt_q <= '0;
      need_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (push_i) begin
        len_q  <= len_d;
        fail_q <= fail_d;
        pcnt_q <= pcnt_d;
        need_q <= need_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && pend_we) begin
      pend_q[pend_wa] <= c;
    end
  end

endmodule

>>> rtl/jsesc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsesc_fifo
// Short request queue between the front and back ends.
// ----------------------------------------------------------------------------
module jsesc_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  jsesc_pkg::burst_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output jsesc_pkg::burst_t rdata_o
);

  jsesc_pkg::burst_t                mem_q [jsesc_pkg::QUEUE_DEPTH];
  logic [jsesc_pkg::QPTR_W-1:0]     wptr_q, rptr_q;
  logic [jsesc_pkg::QCNT_W-1:0]     cnt_q;

  localparam logic [jsesc_pkg::QPTR_W-1:0] PTR_LAST =
    jsesc_pkg::QPTR_W'(jsesc_pkg::QUEUE_DEPTH - 1);
  localparam logic [jsesc_pkg::QCNT_W-1:0] CNT_FULL =
    jsesc_pkg::QCNT_W'(jsesc_pkg::QUEUE_DEPTH);

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue pop while empty");

endmodule

>>> rtl/jsesc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsesc_back
// Serialises each queued request: a result per byte, or one if it has none.
// ----------------------------------------------------------------------------
module jsesc_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         empty_i,
  input  jsesc_pkg::burst_t            head_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   out_byte_o,
  output logic                         byte_valid_o,
  output logic                         last_o,
  output logic                         fail_o,
  output logic [jsesc_pkg::TOTAL_W-1:0] length_o
);

  logic [jsesc_pkg::IDX_W-1:0]   idx_q;
  logic [jsesc_pkg::CNT_W-1:0]   total;
  logic                          last, load;
  logic                          valid_q;
  logic [7:0]                    byte_q;
  logic                          bval_q, last_q, fail_q;
  logic [jsesc_pkg::TOTAL_W-1:0] len_q;

  assign total = (head_i.count == '0) ? jsesc_pkg::CNT_W'(1) : head_i.count;
  assign last  = (jsesc_pkg::CNT_W'(idx_q) + jsesc_pkg::CNT_W'(1) == total);
  assign load  = !empty_i && (!valid_q || out_ready_i);
  assign pop_o = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= last ? '0 : idx_q + 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= (head_i.count == '0) ? 8'h00 : head_i.bytes[idx_q];
      bval_q <= (head_i.count != '0);
      last_q <= last;
      fail_q <= head_i.fail;
      len_q  <= head_i.length;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign byte_valid_o = bval_q;
  assign last_o       = last_q;
  assign fail_o       = fail_q;
  assign length_o     = len_q;

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !bval_q) |-> last_q)
    else $error("status-only result not marked last");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> (jsesc_pkg::CNT_W'(idx_q) < total))
    else $error("serialiser index beyond request length");

endmodule

>>> rtl/json_string_escaper_utf8_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_escaper_utf8_checker
// JSON string writer: escapes string bytes, checks UTF-8, tracks length.
// ----------------------------------------------------------------------------
// Path: an accepted item is queued, then the back end registers its results.
// Throughput: one result per cycle while the output is ready; an item with n
// results holds the serialiser until done, so single-byte items flow one per cycle.
// The two-entry request queue lets the front accept while the back serialises.
// Reset: length, fail flag and held sequence clear, capacity returns to 1024.
module json_string_escaper_utf8_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,     // buffer_capacity
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
  input  logic [2:0]  s_axis_tuser,    // [2:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,    // [7:0] out_byte, [23:8] total_length
  output logic [1:0]  m_axis_tuser,    // [0] byte_valid, [1] fail_state
  output logic        m_axis_tlast     // last_of_run
);

  jsesc_pkg::burst_t             wr_burst, head;
  logic                          full, empty, push, pop;
  logic [7:0]                    out_byte;
  logic                          byte_valid, fail_state;
  logic [jsesc_pkg::TOTAL_W-1:0] total_length;

  assign s_axis_tready = !full;
  assign push          = s_axis_tvalid && !full;

  jsesc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .command_i   (s_axis_tuser),
    .data_byte_i (s_axis_tdata),
    .burst_o     (wr_burst)
  );

  jsesc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wr_burst),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (head)
  );

  jsesc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (out_byte),
    .byte_valid_o (byte_valid),
    .last_o       (m_axis_tlast),
    .fail_o       (fail_state),
    .length_o     (total_length)
  );

  assign m_axis_tdata = {total_length, out_byte};
  assign m_axis_tuser = {fail_state, byte_valid};

endmodule

>>> tb/tb_json_string_escaper_utf8_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_string_escaper_utf8_checker
// Self-checking bench for the JSON string writer. Requests go in on the slave
// stream as a command and a data byte. A behavioural model of the writer
// predicts every output character and status beat: escaping, UTF-8 holding
// and checking, capacity limits and the sticky fail flag. A checker compares
// each beat on the master stream with the oldest prediction. Directed cases
// cover the escapes and the UTF-8 rules. Random JSON-like frames with some
// noise then run under several buffer capacities, with random gaps on both
// streams in all but one run.
// ----------------------------------------------------------------------------
module tb_json_string_escaper_utf8_checker;

  localparam int unsigned       STALL_LIMIT   = 1000;
  localparam logic [2:0]        CMD_UNUSED_HI = 3'd7;
  localparam logic [7:0]        CONT_TOP      = 8'hBF;
  localparam logic [8*16-1:0]   HEX_DIGITS    = "0123456789abcdef";

  typedef struct {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last_of_run;
    logic        fail_state;
    logic [15:0] total_length;
  } beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // writer model state
  int          buf_cap;
  int          wr_len;
  bit          writer_failed;
  logic [7:0]  held_seq [3];
  int          held_cnt;
  int          held_need;
  logic [7:0]  chunk_q[$];
  logic [7:0]  emit_q[$];

  beat_t       expected_beats[$];
  int          mismatch_count = 0;
  int          requests_sent = 0;
  int          ready_hold = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_en = 1'b1;

  json_string_escaper_utf8_checker u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model
  function automatic void set_failed();
    writer_failed = 1'b1;
    wr_len = 0;
  endfunction

  function automatic void drop_held();
    held_cnt = 0;
    held_need = 0;
  endfunction

  function automatic void commit_chunk();
    int n;
    n = chunk_q.size();
    if (writer_failed || buf_cap == 0 || wr_len >= buf_cap ||
        n > buf_cap - 1 - wr_len || wr_len + n > 16'hFFFF) begin
      set_failed();
    end else begin
      foreach (chunk_q[i]) emit_q.push_back(chunk_q[i]);
      wr_len += n;
    end
    chunk_q.delete();
  endfunction

  function automatic void model_string_byte(logic [7:0] c);
    logic [7:0] esc;
    logic       bad;
    logic [7:0] lead;
    esc = '0;
    if (held_cnt == 0) begin
      if (c < jsesc_pkg::ASCII_TOP) begin
        case (c)
          jsesc_pkg::CH_QUOTE: esc = jsesc_pkg::CH_QUOTE;
          jsesc_pkg::CH_BSL:   esc = jsesc_pkg::CH_BSL;
          jsesc_pkg::CH_BS:    esc = jsesc_pkg::CH_B;
          jsesc_pkg::CH_FF:    esc = jsesc_pkg::CH_F;
          jsesc_pkg::CH_LF:    esc = jsesc_pkg::CH_N;
          jsesc_pkg::CH_CR:    esc = jsesc_pkg::CH_R;
          jsesc_pkg::CH_TAB:   esc = jsesc_pkg::CH_T;
          default:             esc = '0;
        endcase
        if (esc != 0) begin
          chunk_q.push_back(jsesc_pkg::CH_BSL);
          chunk_q.push_back(esc);
        end else if (c < jsesc_pkg::CTRL_TOP) begin
          chunk_q.push_back(jsesc_pkg::CH_BSL);
          chunk_q.push_back(jsesc_pkg::CH_U);
          chunk_q.push_back(jsesc_pkg::CH_ZERO);
          chunk_q.push_back(jsesc_pkg::CH_ZERO);
          chunk_q.push_back(HEX_DIGITS[8*(15-c[7:4]) +: 8]);
          chunk_q.push_back(HEX_DIGITS[8*(15-c[3:0]) +: 8]);
        end else begin
          chunk_q.push_back(c);
        end
        commit_chunk();
        return;
      end
      if (c >= jsesc_pkg::LEAD2_LO && c <= jsesc_pkg::LEAD2_HI) held_need = 1;
      else if (c >= jsesc_pkg::LEAD3_LO && c <= jsesc_pkg::LEAD3_HI) held_need = 2;
      else if (c >= jsesc_pkg::LEAD4_LO && c <= jsesc_pkg::LEAD4_HI) held_need = 3;
      else begin
        set_failed();
        return;
      end
      held_seq[0] = c;
      held_cnt = 1;
      return;
    end
    bad = (c[7:6] != 2'b10);
    if (held_cnt == 1) begin
      lead = held_seq[0];
      if ((lead == jsesc_pkg::LEAD3_LO && c < jsesc_pkg::CONT_A0) ||
          (lead == jsesc_pkg::LEAD_ED && c >= jsesc_pkg::CONT_A0) ||
          (lead == jsesc_pkg::LEAD4_LO && c < jsesc_pkg::CONT_90) ||
          (lead == jsesc_pkg::LEAD4_HI && c >= jsesc_pkg::CONT_90))
        bad = 1'b1;
    end
    if (bad) begin
      drop_held();
      set_failed();
      return;
    end
    if (held_cnt < held_need) begin
      held_seq[held_cnt] = c;
      held_cnt++;
      return;
    end
    for (int i = 0; i < held_cnt; i++) chunk_q.push_back(held_seq[i]);
    chunk_q.push_back(c);
    drop_held();
    commit_chunk();
  endfunction

  function automatic void predict_request(logic [2:0] cmd, logic [7:0] data);
    beat_t b;
    int    n;
    emit_q.delete();
    chunk_q.delete();
    if (cmd == jsesc_pkg::CMD_RESET) begin
      wr_len = 0;
      drop_held();
      writer_failed = (buf_cap == 0);
    end else if (cmd <= jsesc_pkg::CMD_RAW && cmd != jsesc_pkg::CMD_STRING &&
                 held_cnt != 0) begin
      drop_held();
      set_failed();
    end else if (cmd == jsesc_pkg::CMD_OPEN || cmd == jsesc_pkg::CMD_CLOSE) begin
      chunk_q.push_back(jsesc_pkg::CH_QUOTE);
      commit_chunk();
    end else if (cmd == jsesc_pkg::CMD_STRING) begin
      model_string_byte(data);
    end else if (cmd == jsesc_pkg::CMD_RAW) begin
      chunk_q.push_back(data);
      commit_chunk();
    end
    n = (emit_q.size() == 0) ? 1 : emit_q.size();
    for (int k = 0; k < n; k++) begin
      b.out_byte     = (emit_q.size() == 0) ? 8'h00 : emit_q[k];
      b.byte_valid   = (emit_q.size() != 0);
      b.last_of_run  = (k == n - 1);
      b.fail_state   = writer_failed;
      b.total_length = wr_len[15:0];
      expected_beats.push_back(b);
    end
  endfunction

  // ------------------------------------------------------------- drivers
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (!idle_en || r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  task automatic send_request(input logic [2:0] cmd, input logic [7:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_request(cmd, data);
    requests_sent++;
  endtask

  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [15:0] cap);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    buf_cap = int'(cap);
  endtask

  always @(posedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (idle_en && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 3);
    end else begin
      m_axis_tready <= 1'b1;
      ready_hold <= $urandom_range(0, 5);
    end
  end

  // --------------------------------------------------------------- checks
  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    beat_t b;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected output beat %0h", m_axis_tdata);
        mismatch_count++;
      end else begin
        b = expected_beats.pop_front();
        check_field("out_byte", 16'(b.out_byte), 16'(m_axis_tdata[7:0]));
        check_field("byte_valid", 16'(b.byte_valid), 16'(m_axis_tuser[0]));
        check_field("last_of_run", 16'(b.last_of_run), 16'(m_axis_tlast));
        check_field("fail_state", 16'(b.fail_state), 16'(m_axis_tuser[1]));
        check_field("total_length", b.total_length, m_axis_tdata[23:8]);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_escapes();
    send_request(jsesc_pkg::CMD_RESET, 8'h00);
    send_request(jsesc_pkg::CMD_OPEN, 8'hFF);
    send_request(jsesc_pkg::CMD_STRING, jsesc_pkg::CH_QUOTE);
    send_request(jsesc_pkg::CMD_STRING, jsesc_pkg::CH_BSL);
    send_request(jsesc_pkg::CMD_STRING, jsesc_pkg::CH_BS);
    send_request(jsesc_pkg::CMD_STRING, jsesc_pkg::CH_FF);
    send_request(jsesc_pkg::CMD_STRING, jsesc_pkg::CH_LF);
    send_request(jsesc_pkg::CMD_STRING, jsesc_pkg::CH_CR);
    send_request(jsesc_pkg::CMD_STRING, jsesc_pkg::CH_TAB);
    send_request(jsesc_pkg::CMD_STRING, 8'h00);
    send_request(jsesc_pkg::CMD_STRING, 8'h1F);
    send_request(jsesc_pkg::CMD_CLOSE, 8'h00);
    send_request(jsesc_pkg::CMD_RAW, 8'hFF);
    send_request(CMD_UNUSED_HI, 8'hFF);
    settle_block();
  endtask

  task automatic test_utf8_rules();
    send_request(jsesc_pkg::CMD_RESET, 8'h00);
    send_request(jsesc_pkg::CMD_STRING, jsesc_pkg::LEAD2_LO);
    send_request(jsesc_pkg::CMD_STRING, jsesc_pkg::ASCII_TOP);
    send_request(jsesc_pkg::CMD_STRING, jsesc_pkg::LEAD4_HI);
    send_request(jsesc_pkg::CMD_STRING, 8'h8F);
    send_request(jsesc_pkg::CMD_STRING, CONT_TOP);
    send_request(jsesc_pkg::CMD_STRING, CONT_TOP);
    send_request(jsesc_pkg::CMD_STRING, jsesc_pkg::LEAD3_LO);
    send_request(jsesc_pkg::CMD_STRING, 8'h9F);
    send_request(jsesc_pkg::CMD_STRING, 8'hF5);
    send_request(jsesc_pkg::CMD_STRING, 8'hE2);
    send_request(jsesc_pkg::CMD_RAW, 8'h41);
    send_request(jsesc_pkg::CMD_RESET, 8'h00);
    settle_block();
  endtask

  task automatic send_utf8_char();
    logic [7:0] lead;
    logic [7:0] lo;
    logic [7:0] hi;
    case ($urandom_range(0, 9)) inside
      [0:2]: send_request(jsesc_pkg::CMD_STRING,
                          8'($urandom_range(jsesc_pkg::CTRL_TOP, 8'h7F)));
      3: send_request(jsesc_pkg::CMD_STRING,
                      8'($urandom_range(0, jsesc_pkg::CTRL_TOP - 1)));
      4: send_request(jsesc_pkg::CMD_STRING,
                      ($urandom_range(0, 1) != 0) ? jsesc_pkg::CH_QUOTE : jsesc_pkg::CH_BSL);
      5: begin
        send_request(jsesc_pkg::CMD_STRING,
                     8'($urandom_range(jsesc_pkg::LEAD2_LO, jsesc_pkg::LEAD2_HI)));
        send_request(jsesc_pkg::CMD_STRING,
                     8'($urandom_range(jsesc_pkg::ASCII_TOP, CONT_TOP)));
      end
      6: begin
        lead = 8'($urandom_range(jsesc_pkg::LEAD3_LO, jsesc_pkg::LEAD3_HI));
        lo = (lead == jsesc_pkg::LEAD3_LO) ? jsesc_pkg::CONT_A0 : jsesc_pkg::ASCII_TOP;
        hi = (lead == jsesc_pkg::LEAD_ED) ? jsesc_pkg::CONT_A0 - 8'd1 : CONT_TOP;
        send_request(jsesc_pkg::CMD_STRING, lead);
        send_request(jsesc_pkg::CMD_STRING, 8'($urandom_range(lo, hi)));
        send_request(jsesc_pkg::CMD_STRING,
                     8'($urandom_range(jsesc_pkg::ASCII_TOP, CONT_TOP)));
      end
      7: begin
        lead = 8'($urandom_range(jsesc_pkg::LEAD4_LO, jsesc_pkg::LEAD4_HI));
        lo = (lead == jsesc_pkg::LEAD4_LO) ? jsesc_pkg::CONT_90 : jsesc_pkg::ASCII_TOP;
        hi = (lead == jsesc_pkg::LEAD4_HI) ? jsesc_pkg::CONT_90 - 8'd1 : CONT_TOP;
        send_request(jsesc_pkg::CMD_STRING, lead);
        send_request(jsesc_pkg::CMD_STRING, 8'($urandom_range(lo, hi)));
        send_request(jsesc_pkg::CMD_STRING,
                     8'($urandom_range(jsesc_pkg::ASCII_TOP, CONT_TOP)));
        send_request(jsesc_pkg::CMD_STRING,
                     8'($urandom_range(jsesc_pkg::ASCII_TOP, CONT_TOP)));
      end
      8: begin
        send_request(jsesc_pkg::CMD_STRING,
                     8'($urandom_range(jsesc_pkg::ASCII_TOP, 8'hFF)));
        if ($urandom_range(0, 1) != 0)
          send_request(jsesc_pkg::CMD_STRING, 8'($urandom_range(0, 255)));
      end
      default: begin
        send_request(jsesc_pkg::CMD_STRING,
                     8'($urandom_range(jsesc_pkg::LEAD2_LO, jsesc_pkg::LEAD4_HI)));
        if ($urandom_range(0, 1) != 0)
          send_request(jsesc_pkg::CMD_RAW, 8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  task automatic test_random_frames(input logic [15:0] cap, input int n_requests,
                                    input bit gaps);
    int stop_at;
    settle_block();
    write_capacity(cap);
    idle_en = gaps;
    stop_at = requests_sent + n_requests;
    while (requests_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 3) != 0)
          send_request(jsesc_pkg::CMD_RESET, 8'($urandom_range(0, 255)));
        send_request(jsesc_pkg::CMD_OPEN, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 8)) send_utf8_char();
        send_request(jsesc_pkg::CMD_CLOSE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 2) == 0)
          send_request(jsesc_pkg::CMD_RAW, 8'($urandom_range(0, 255)));
      end
    end
    settle_block();
    idle_en = 1'b1;
  endtask

  initial begin
    buf_cap       = int'(jsesc_pkg::CAP_RESET);
    wr_len        = 0;
    writer_failed = 1'b0;
    drop_held();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_escapes();
    test_utf8_rules();
    test_random_frames(jsesc_pkg::CAP_RESET, 100, 1'b1);
    test_random_frames(16'd40, 60, 1'b1);
    test_random_frames(16'hFFFF, 60, 1'b0);
    test_random_frames(16'd2, 30, 1'b1);
    test_random_frames(16'd0, 20, 1'b1);
    test_random_frames(16'd1, 20, 1'b1);
    test_random_frames(16'($urandom_range(3, 200)), 70, 1'b1);

    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
